>>> sv/iptc_pkg.sv
// ----------------------------------------------------------------------------
// iptc_pkg
// Shared types and constants for the IPTC dataset stream parser: parse
// phases, result kinds and the word carried from the front to the back.
// ----------------------------------------------------------------------------
package iptc_pkg;

    // tag framing bytes
    localparam logic [7:0] TAG_MARKER   = 8'h1c;
    localparam logic [7:0] RECORD_ONE   = 8'h01;
    localparam logic [7:0] RECORD_TWO   = 8'h02;
    localparam logic [7:0] LONG_LEN_BIT = 8'h80;

    // number of bytes in a long length
    localparam logic [2:0] LONG_LEN_BYTES = 3'd4;

    // parse phase
    typedef enum logic [3:0] {
        PH_SCAN       = 4'd0,
        PH_MARKER     = 4'd1,
        PH_DATASET    = 4'd2,
        PH_RECORD     = 4'd3,
        PH_LEN_FIRST  = 4'd4,
        PH_LEN_SECOND = 4'd5,
        PH_LEN_SKIP   = 4'd6,
        PH_LEN_LONG   = 4'd7,
        PH_PAYLOAD    = 4'd8,
        PH_STOPPED    = 4'd9
    } phase_t;

    // result kind
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    // classified work for one input byte
    typedef struct packed {
        logic        has_main;   // header or payload result
        kind_t       main_kind;
        logic [7:0]  dataset;
        logic [7:0]  record_no;
        logic [31:0] length;
        logic [7:0]  payload;
        logic [31:0] count;      // tag count after this byte
        logic        has_end;    // end of buffer result follows
    } entry_t;

endpackage

>>> sv/iptc_front.sv
// ----------------------------------------------------------------------------
// iptc_front
// Parse front end: takes one buffer byte per cycle while accept is high,
// walks the tag state machine and turns each byte with results into one queue word describing them.
// ----------------------------------------------------------------------------
module iptc_front
    import iptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [31:0] total_length,
    output logic        push,
    output entry_t      push_entry
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] size_reg, size_next;
    logic        prev_marker_reg, prev_marker_next;
    logic [7:0]  dataset_reg, dataset_next;
    logic [7:0]  record_reg, record_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] tags_reg, tags_next;

    // state as seen by this byte, a first byte restarting the parse
    phase_t      e_phase;
    logic [31:0] e_pos;
    logic [31:0] e_size;
    logic        e_prev_marker;
    logic [7:0]  e_dataset;
    logic [7:0]  e_record;
    logic [31:0] e_len;
    logic [2:0]  e_idx;
    logic [31:0] e_remain;
    logic [31:0] e_tags;

    always_comb
    begin
        if (first_byte)
        begin
            e_phase       = PH_SCAN;
            e_pos         = '0;
            e_size        = total_length;
            e_prev_marker = 1'b0;
            e_dataset     = '0;
            e_record      = '0;
            e_len         = '0;
            e_idx         = '0;
            e_remain      = '0;
            e_tags        = '0;
        end
        else
        begin
            e_phase       = phase_reg;
            e_pos         = pos_reg;
            e_size        = size_reg;
            e_prev_marker = prev_marker_reg;
            e_dataset     = dataset_reg;
            e_record      = record_reg;
            e_len         = len_reg;
            e_idx         = idx_reg;
            e_remain      = remain_reg;
            e_tags        = tags_reg;
        end
    end

    // shared checks
    logic        in_range;
    logic [31:0] pos_inc;
    logic        dataset_fail;
    logic        long_fail;
    logic [31:0] len_shift;
    logic [33:0] tag_end;
    logic        fit_fail;
    logic [2:0]  idx_inc;
    logic        is_record;
    logic        at_last;

    assign in_range     = e_pos < e_size;
    assign pos_inc      = e_pos + 32'd1;
    assign dataset_fail = ({2'b00, e_pos} + 34'd4) >= {2'b00, e_size};
    assign long_fail    = ({2'b00, e_pos} + 34'd6) >= {2'b00, e_size};
    assign len_shift    = {e_len[23:0], data_byte};
    assign tag_end      = {2'b00, e_pos} + 34'd1 + {2'b00, len_shift};
    assign fit_fail     = (len_shift > e_size) || (tag_end > {2'b00, e_size});
    assign idx_inc      = e_idx + 3'd1;
    assign is_record    = (data_byte == RECORD_ONE) || (data_byte == RECORD_TWO);
    assign at_last      = in_range && (pos_inc == e_size);

    // next state
    always_comb
    begin
        phase_next       = e_phase;
        pos_next         = e_pos;
        size_next        = e_size;
        prev_marker_next = e_prev_marker;
        dataset_next     = e_dataset;
        record_next      = e_record;
        len_next         = e_len;
        idx_next         = e_idx;
        remain_next      = e_remain;
        tags_next        = e_tags;
        if (in_range)
        begin
            pos_next = pos_inc;
            case (e_phase)
                PH_SCAN:
                begin
                    if (e_prev_marker && is_record)
                    begin
                        if (dataset_fail)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else
                        begin
                            dataset_next = data_byte;
                            phase_next   = PH_RECORD;
                        end
                    end
                    else
                    begin
                        prev_marker_next = (data_byte == TAG_MARKER);
                    end
                end
                PH_MARKER:
                begin
                    phase_next = (data_byte == TAG_MARKER) ? PH_DATASET : PH_STOPPED;
                end
                PH_DATASET:
                begin
                    if (dataset_fail)
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else
                    begin
                        dataset_next = data_byte;
                        phase_next   = PH_RECORD;
                    end
                end
                PH_RECORD:
                begin
                    record_next = data_byte;
                    phase_next  = PH_LEN_FIRST;
                end
                PH_LEN_FIRST:
                begin
                    if ((data_byte & LONG_LEN_BIT) != 8'h00)
                    begin
                        phase_next = long_fail ? PH_STOPPED : PH_LEN_SKIP;
                    end
                    else
                    begin
                        len_next   = {24'd0, data_byte};
                        phase_next = PH_LEN_SECOND;
                    end
                end
                PH_LEN_SECOND, PH_LEN_LONG:
                begin
                    len_next = len_shift;
                    if (e_phase == PH_LEN_LONG)
                    begin
                        idx_next = idx_inc;
                    end
                    if ((e_phase == PH_LEN_SECOND) || (idx_inc >= LONG_LEN_BYTES))
                    begin
                        if (fit_fail)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else
                        begin
                            tags_next = e_tags + 32'd1;
                            if (len_shift == 32'd0)
                            begin
                                phase_next = PH_MARKER;
                            end
                            else
                            begin
                                remain_next = len_shift;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_LEN_SKIP:
                begin
                    len_next   = '0;
                    idx_next   = '0;
                    phase_next = PH_LEN_LONG;
                end
                PH_PAYLOAD:
                begin
                    remain_next = e_remain - 32'd1;
                    if (e_remain == 32'd1)
                    begin
                        phase_next = PH_MARKER;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // queue word for this byte
    always_comb
    begin
        push_entry           = '0;
        push_entry.main_kind = KIND_HEADER;
        push_entry.dataset   = e_dataset;
        push_entry.record_no = e_record;
        push_entry.length    = e_len;
        push_entry.count     = e_tags;
        push_entry.has_end   = at_last;
        if (in_range)
        begin
            case (e_phase)
                PH_LEN_SECOND:
                begin
                    push_entry.has_main = !fit_fail;
                    push_entry.length   = len_shift;
                    push_entry.count    = fit_fail ? e_tags : e_tags + 32'd1;
                end
                PH_LEN_LONG:
                begin
                    push_entry.has_main = (idx_inc >= LONG_LEN_BYTES) && !fit_fail;
                    push_entry.length   = len_shift;
                    push_entry.count    = push_entry.has_main ? e_tags + 32'd1 : e_tags;
                end
                PH_PAYLOAD:
                begin
                    push_entry.has_main  = 1'b1;
                    push_entry.main_kind = KIND_PAYLOAD;
                    push_entry.payload   = data_byte;
                end
                default:
                begin
                end
            endcase
        end
        push = accept && (push_entry.has_main || push_entry.has_end);
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SCAN;
            pos_reg         <= '0;
            size_reg        <= '0;
            prev_marker_reg <= 1'b0;
            dataset_reg     <= '0;
            record_reg      <= '0;
            len_reg         <= '0;
            idx_reg         <= '0;
            remain_reg      <= '0;
            tags_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            size_reg        <= size_next;
            prev_marker_reg <= prev_marker_next;
            dataset_reg     <= dataset_next;
            record_reg      <= record_next;
            len_reg         <= len_next;
            idx_reg         <= idx_next;
            remain_reg      <= remain_next;
            tags_reg        <= tags_next;
        end
    end

endmodule

>>> sv/iptc_fifo.sv
// ----------------------------------------------------------------------------
// iptc_fifo
// Short queue of classified words between the parse front and the result
// back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module iptc_fifo
    import iptc_pkg::*;
#(
    parameter int Depth = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(Depth);
    localparam logic [AW-1:0] PTR_ONE = AW'(1);
    localparam logic [CW-1:0] COUNT_ONE = CW'(1);

    entry_t        mem_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

>>> sv/iptc_back.sv
// ----------------------------------------------------------------------------
// iptc_back
// Result back end: expands each queue word into one or two result words
// and holds the current one in the output register until it is taken.
// ----------------------------------------------------------------------------
module iptc_back
    import iptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  dataset_number,
    output logic [7:0]  record_number,
    output logic [31:0] tag_length,
    output logic [7:0]  payload_byte,
    output logic [31:0] tag_count,
    output logic        last_of_run
);

    logic        valid_reg, valid_next;
    logic        main_sent_reg, main_sent_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  dataset_reg, dataset_next;
    logic [7:0]  record_reg, record_next;
    logic [31:0] length_reg, length_next;
    logic [7:0]  payload_reg, payload_next;
    logic [31:0] count_reg, count_next;
    logic        last_reg, last_next;
    logic        load;

    // output register free or being emptied this cycle
    assign load = !valid_reg || !out_stall;

    // pick the next result word from the queue head
    always_comb
    begin
        valid_next     = valid_reg;
        main_sent_next = main_sent_reg;
        kind_next      = kind_reg;
        dataset_next   = dataset_reg;
        record_next    = record_reg;
        length_next    = length_reg;
        payload_next   = payload_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                count_next = head_entry.count;
                if (head_entry.has_main && !main_sent_reg)
                begin
                    kind_next    = head_entry.main_kind;
                    dataset_next = head_entry.dataset;
                    record_next  = head_entry.record_no;
                    length_next  = head_entry.length;
                    payload_next = head_entry.payload;
                    last_next    = !head_entry.has_end;
                    if (head_entry.has_end)
                    begin
                        main_sent_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    kind_next      = KIND_END;
                    dataset_next   = '0;
                    record_next    = '0;
                    length_next    = '0;
                    payload_next   = '0;
                    last_next      = 1'b1;
                    main_sent_next = 1'b0;
                    pop            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            main_sent_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            main_sent_reg <= main_sent_next;
        end
    end

    // result word fields
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        dataset_reg <= dataset_next;
        record_reg  <= record_next;
        length_reg  <= length_next;
        payload_reg <= payload_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign dataset_number = dataset_reg;
    assign record_number  = record_reg;
    assign tag_length     = length_reg;
    assign payload_byte   = payload_reg;
    assign tag_count      = count_reg;
    assign last_of_run    = last_reg;

`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_END)) |-> last_reg)
        else $error("end word not marked last");

    a_split_word_pending: assert property (@(posedge clk) disable iff (!rst_n)
        main_sent_reg |-> head_valid && head_entry.has_end)
        else $error("second result pending without queue word");
`endif

endmodule

>>> sv/iptc_dataset_stream_parser.sv
// ----------------------------------------------------------------------------
// iptc_dataset_stream_parser
// IPTC dataset stream parser top level: parse front, word queue, result back.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle while in_stall is low (first_byte
// restarts the parse and loads total_length) and emits tag headers, payload
// bytes and one end word on the last byte of the buffer. The front end
// classifies each byte combinationally, so input words are taken back to
// back; the output register delivers one result word per cycle while
// out_stall is low, so a byte that gives two results (a tag or its last
// payload byte on the final buffer byte) gives two words, the Depth-entry
// queue absorbing the difference. Results pass the queue, then the output register.
// ----------------------------------------------------------------------------
module iptc_dataset_stream_parser
    import iptc_pkg::*;
#(
    parameter int Depth = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [31:0] total_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  dataset_number,
    output logic [7:0]  record_number,
    output logic [31:0] tag_length,
    output logic [7:0]  payload_byte,
    output logic [31:0] tag_count,
    output logic        last_of_run
);

    logic   full;
    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    // input side stalls only on a full queue
    assign in_stall = full;
    assign accept   = in_valid && !full;

    iptc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .total_length (total_length),
        .push         (push),
        .push_entry   (push_entry)
    );

    iptc_fifo #(
        .Depth (Depth)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    iptc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .dataset_number (dataset_number),
        .record_number  (record_number),
        .tag_length     (tag_length),
        .payload_byte   (payload_byte),
        .tag_count      (tag_count),
        .last_of_run    (last_of_run)
    );

endmodule
